/* design/stereo_biquad_filter_top_assert.svh */
// Assertion macros used by the stereo biquad filter top level.
`ifndef STEREO_BIQUAD_FILTER_TOP_ASSERT_SVH
`define STEREO_BIQUAD_FILTER_TOP_ASSERT_SVH
// The expression must hold at the same clock edge as the trigger.
`define SBQ_ASSERT_SAME(label, clk, rst_n, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
		else $error(msg);
// The expression must hold at the clock edge after the trigger.
`define SBQ_ASSERT_NEXT(label, clk, rst_n, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
		else $error(msg);
`endif

/* design/sbq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the stereo biquad filter.
package sbq_pkg;

	localparam int DEF_SAMPLE_BITS    = 24;
	localparam int DEF_COEF_FRAC_BITS = 20;

	// Width of one multiplier digit consumed per cycle.
	localparam int DIGIT_BITS = 4;
	// Width of the intermediate value between the two rounding steps.
	localparam int MID_BITS   = 40;

	localparam int CFG_TYPE_W  = 3;
	localparam int CFG_COS_W   = 22;
	localparam int CFG_ALPHA_W = 20;
	localparam int CFG_GAIN_W  = 21;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_TYPE_W-1:0]         RST_FILTER_TYPE = '0;
	localparam logic signed [CFG_COS_W-1:0]   RST_COS_W0      = 22'sd1039594;
	localparam logic [CFG_ALPHA_W-1:0]        RST_ALPHA       = 20'd68432;
	localparam logic [CFG_GAIN_W-1:0]         RST_NORM_GAIN   = 21'd984330;

	localparam logic CH_LEFT  = 1'b0;
	localparam logic CH_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		REG_FILTER_TYPE = 2'd0,
		REG_COS_W0      = 2'd1,
		REG_ALPHA       = 2'd2,
		REG_NORM_GAIN   = 2'd3
	} reg_idx_t;

	typedef enum logic [CFG_TYPE_W-1:0] {
		FT_LOWPASS  = 3'd0,
		FT_HIGHPASS = 3'd1,
		FT_BANDPASS = 3'd2,
		FT_BANDSTOP = 3'd3,
		FT_ALLPASS  = 3'd4
	} filt_t;

	// Product terms of one channel, in the order they are accumulated.
	typedef enum logic [2:0] {
		TERM_CUR  = 3'd0,
		TERM_IN1  = 3'd1,
		TERM_IN2  = 3'd2,
		TERM_OUT1 = 3'd3,
		TERM_OUT2 = 3'd4,
		TERM_DONE = 3'd5
	} term_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_LOAD  = 3'd1,
		ST_STEP  = 3'd2,
		ST_RND   = 3'd3,
		ST_MID   = 3'd4,
		ST_GSTEP = 3'd5,
		ST_FIN   = 3'd6
	} state_t;

	typedef enum logic [2:0] {
		MOP_HOLD = 3'd0,
		MOP_LOAD = 3'd1,
		MOP_STEP = 3'd2,
		MOP_RND  = 3'd3,
		MOP_MID  = 3'd4
	} mac_op_t;

	typedef struct packed {
		mac_op_t op;
		logic    first;
	} mac_cmd_t;

	typedef struct packed {
		logic last;
	} mac_stat_t;

	// Coefficients are held at twice their value; this width covers all five shapes.
	function automatic int coef_width(input int frac_bits);
		int base;
		base = (CFG_COS_W > frac_bits + 2) ? CFG_COS_W : frac_bits + 2;
		return base + 4;
	endfunction

endpackage

/* design/stereo_biquad_filter_top.sv */
`timescale 1ns / 1ps
// Stereo direct form 1 biquad filter: top level with sequencer, history and APB registers.
// Each sample beat runs through the left channel, then the right, and result_valid rises once
// both are done; ND = ceil(max(SAMPLE_BITS, 22) / 4) is the digit count of the serial
// multiplier (ND = 6 by default). A new beat is taken only once the last one has finished.
// The single 4-bit digit multiply-accumulate unit is shared by all ten products and both gain
// multiplies. Reset clears history, registers and the result valid flag.
`include "stereo_biquad_filter_top_assert.svh"

module stereo_biquad_filter_top import sbq_pkg::*; #(
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel.
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	// Output channel.
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_ADDR_W-1:0]         paddr,
	input  logic [APB_DATA_W-1:0]         pwdata,
	output logic [APB_DATA_W-1:0]         prdata,
	output logic                          pready
);

	localparam int KW = coef_width(COEF_FRAC_BITS);
	localparam logic signed [KW-1:0] ONE = signed'(KW'(1) << COEF_FRAC_BITS);

	// Configuration registers.
	logic [CFG_TYPE_W-1:0]       type_q;
	logic signed [CFG_COS_W-1:0] cos_q;
	logic [CFG_ALPHA_W-1:0]      alpha_q;
	logic [CFG_GAIN_W-1:0]       gain_q;

	// Sequencer.
	state_t    state_q, state_d;
	term_t     term_q;
	logic      ch_q;
	mac_cmd_t  cmd;
	mac_stat_t stat;
	logic      take, adv, fin_l, fin_r;

	// Sample beat, per-channel history and results.
	logic signed [SAMPLE_BITS-1:0] x_q    [2];
	logic signed [SAMPLE_BITS-1:0] in1_q  [2];
	logic signed [SAMPLE_BITS-1:0] in2_q  [2];
	logic signed [SAMPLE_BITS-1:0] out1_q [2];
	logic signed [SAMPLE_BITS-1:0] out2_q [2];
	logic signed [SAMPLE_BITS-1:0] yl_q;
	logic signed [SAMPLE_BITS-1:0] res_l_q, res_r_q;
	logic                          out_valid_q;

	logic signed [KW-1:0]          c_ext, a_ext, k0, k1, k2, coef;
	logic signed [SAMPLE_BITS-1:0] operand;
	logic signed [SAMPLE_BITS-1:0] y_mac;

	logic reg_wr;
	reg_idx_t reg_idx;

	// ---------------------------------------------------------------------------------------
	// APB register file. Writes complete in the access phase; pready is tied high.
	// ---------------------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= RST_FILTER_TYPE;
			cos_q   <= RST_COS_W0;
			alpha_q <= RST_ALPHA;
			gain_q  <= RST_NORM_GAIN;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_FILTER_TYPE: type_q  <= pwdata[CFG_TYPE_W-1:0];
				REG_COS_W0:      cos_q   <= signed'(pwdata[CFG_COS_W-1:0]);
				REG_ALPHA:       alpha_q <= pwdata[CFG_ALPHA_W-1:0];
				REG_NORM_GAIN:   gain_q  <= pwdata[CFG_GAIN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FILTER_TYPE: prdata = {{(APB_DATA_W-CFG_TYPE_W){1'b0}}, type_q};
			REG_COS_W0:      prdata = {{(APB_DATA_W-CFG_COS_W){1'b0}}, cos_q};
			REG_ALPHA:       prdata = {{(APB_DATA_W-CFG_ALPHA_W){1'b0}}, alpha_q};
			REG_NORM_GAIN:   prdata = {{(APB_DATA_W-CFG_GAIN_W){1'b0}}, gain_q};
		endcase
	end

	// ---------------------------------------------------------------------------------------
	// Coefficients, held at twice their cookbook value. The feedback terms are stored
	// already negated so that every term is simply added: 4*cos_w0 and -2*(1 - alpha).
	// Unused type codes fall back to the lowpass shape.
	// ---------------------------------------------------------------------------------------
	assign c_ext = KW'(cos_q);
	assign a_ext = signed'(KW'(alpha_q));

	always_comb begin
		unique case (type_q)
			FT_HIGHPASS: begin
				k0 = ONE + c_ext;
				k1 = -((ONE + c_ext) <<< 1);
				k2 = ONE + c_ext;
			end
			FT_BANDPASS: begin
				k0 = a_ext <<< 1;
				k1 = '0;
				k2 = -(a_ext <<< 1);
			end
			FT_BANDSTOP: begin
				k0 = ONE <<< 1;
				k1 = -(c_ext <<< 2);
				k2 = ONE <<< 1;
			end
			FT_ALLPASS: begin
				k0 = (ONE - a_ext) <<< 1;
				k1 = -(c_ext <<< 2);
				k2 = (ONE + a_ext) <<< 1;
			end
			default: begin
				k0 = ONE - c_ext;
				k1 = (ONE - c_ext) <<< 1;
				k2 = ONE - c_ext;
			end
		endcase
	end

	// The term counter picks one coefficient and one sample of the current channel.
	always_comb begin
		unique case (term_q)
			TERM_CUR: begin
				coef    = k0;
				operand = x_q[ch_q];
			end
			TERM_IN1: begin
				coef    = k1;
				operand = in1_q[ch_q];
			end
			TERM_IN2: begin
				coef    = k2;
				operand = in2_q[ch_q];
			end
			TERM_OUT1: begin
				coef    = c_ext <<< 2;
				operand = out1_q[ch_q];
			end
			TERM_OUT2: begin
				coef    = -((ONE - a_ext) <<< 1);
				operand = out2_q[ch_q];
			end
			default: begin
				coef    = '0;
				operand = '0;
			end
		endcase
	end

	// ---------------------------------------------------------------------------------------
	// Sequencer. Per channel: five terms of LOAD plus ND digit steps, a final LOAD that
	// saturates the sum, the first rounding, the load of the gain multiply, ND gain steps
	// and a finish state that writes history. The left channel runs first, then the right.
	// The input side is stalled whenever a beat is in flight; the result register lets a
	// new beat in while the previous result still waits downstream.
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '{op: MOP_HOLD, first: 1'b0};
		sample_stall = 1'b1;
		take         = 1'b0;
		adv          = 1'b0;
		fin_l        = 1'b0;
		fin_r        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					take    = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.op    = MOP_LOAD;
				cmd.first = (term_q == TERM_CUR);
				state_d   = (term_q == TERM_DONE) ? ST_RND : ST_STEP;
			end
			ST_STEP: begin
				cmd.op = MOP_STEP;
				if (stat.last) begin
					adv     = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_RND: begin
				cmd.op  = MOP_RND;
				state_d = ST_MID;
			end
			ST_MID: begin
				cmd.op  = MOP_MID;
				state_d = ST_GSTEP;
			end
			ST_GSTEP: begin
				cmd.op = MOP_STEP;
				if (stat.last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (ch_q == CH_LEFT) begin
					fin_l   = 1'b1;
					state_d = ST_LOAD;
				end else if (!(out_valid_q && result_stall)) begin
					fin_r   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_CUR;
			ch_q   <= CH_LEFT;
		end else begin
			if (take || fin_l) begin
				term_q <= TERM_CUR;
			end else if (adv) begin
				term_q <= term_t'(term_q + 3'd1);
			end
			if (take) begin
				ch_q <= CH_LEFT;
			end else if (fin_l) begin
				ch_q <= CH_RIGHT;
			end
		end
	end

	sbq_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.COEF_W         (KW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.coef    (coef),
		.operand (operand),
		.gain    (gain_q),
		.stat    (stat),
		.y       (y_mac)
	);

	// ---------------------------------------------------------------------------------------
	// Sample capture, filter history and result register.
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (take) begin
			x_q[CH_LEFT]  <= left_in;
			x_q[CH_RIGHT] <= right_in;
		end
		if (fin_l) begin
			yl_q <= y_mac;
		end
		if (fin_r) begin
			res_l_q <= yl_q;
			res_r_q <= y_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				in1_q[i]  <= '0;
				in2_q[i]  <= '0;
				out1_q[i] <= '0;
				out2_q[i] <= '0;
			end
		end else if (fin_l || fin_r) begin
			in1_q[ch_q]  <= x_q[ch_q];
			in2_q[ch_q]  <= in1_q[ch_q];
			out1_q[ch_q] <= y_mac;
			out2_q[ch_q] <= out1_q[ch_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_r) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign left_out     = res_l_q;
	assign right_out    = res_r_q;

	// ---------------------------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------------------------
	`SBQ_ASSERT_SAME(a_result_after_right, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_FIN && $past(ch_q) == CH_RIGHT,
		"result beat raised without finishing the right channel")
	`SBQ_ASSERT_SAME(a_step_term_range, clk, arst_n, state_q == ST_STEP,
		term_q != TERM_DONE, "digit steps running past the last product term")
	`SBQ_ASSERT_SAME(a_round_after_sum, clk, arst_n, state_q == ST_RND,
		$past(state_q) == ST_LOAD && $past(term_q) == TERM_DONE,
		"rounding entered before all five terms were summed")
	`SBQ_ASSERT_SAME(a_channel_switch, clk, arst_n, !$stable(ch_q),
		$past(state_q) == ST_FIN || $past(state_q) == ST_IDLE,
		"channel changed in the middle of a filter pass")
	`SBQ_ASSERT_NEXT(a_left_to_right, clk, arst_n, state_q == ST_FIN && ch_q == CH_LEFT,
		state_q == ST_LOAD && term_q == TERM_CUR && ch_q == CH_RIGHT,
		"right channel pass did not start after the left one")

endmodule

/* design/sbq_mac.sv */
`timescale 1ns / 1ps
// Digit-serial multiply-accumulate unit with the rounding and clamping steps.
module sbq_mac import sbq_pkg::*; #(
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
	parameter int COEF_W         = coef_width(COEF_FRAC_BITS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_cmd_t                      cmd,
	input  logic signed [COEF_W-1:0]      coef,
	input  logic signed [SAMPLE_BITS-1:0] operand,
	input  logic [CFG_GAIN_W-1:0]         gain,
	output mac_stat_t                     stat,
	output logic signed [SAMPLE_BITS-1:0] y
);

	localparam int OPND_W = (SAMPLE_BITS > CFG_GAIN_W + 1) ? SAMPLE_BITS : CFG_GAIN_W + 1;
	localparam int NDIG   = (OPND_W + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int RW     = NDIG * DIGIT_BITS;
	localparam int MW     = (COEF_W > MID_BITS) ? COEF_W : MID_BITS;
	// Always above 64 bits, so the 64-bit saturation is representable.
	localparam int SW     = MW + RW + 4;
	localparam int CW     = $clog2(NDIG);

	localparam logic signed [SW-1:0] LIM_64  = signed'({{(SW-63){1'b0}}, {63{1'b1}}});
	localparam logic signed [SW-1:0] LIM_MID = signed'({{(SW-MID_BITS+1){1'b0}},
		{(MID_BITS-1){1'b1}}});
	localparam logic signed [SW-1:0] LIM_Y   = signed'({{(SW-SAMPLE_BITS+1){1'b0}},
		{(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [SW-1:0] HALF_1  = signed'(SW'(1) << COEF_FRAC_BITS);
	localparam logic signed [SW-1:0] HALF_2  = signed'(SW'(1) << (COEF_FRAC_BITS - 1));

	logic signed [SW-1:0]         m_q;
	logic signed [RW-1:0]         r_q;
	logic signed [SW-1:0]         acc_q;
	logic [CW-1:0]                cnt_q;
	logic                         last;
	logic signed [DIGIT_BITS:0]   dig;
	logic signed [SW+DIGIT_BITS:0] prod;
	logic signed [SW-1:0]         mid_v;
	logic signed [SW-1:0]         y_w;

	// Two-sided clamp to [-(hi+1), hi]; hi is always of the form 2^k-1.
	function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v,
		input logic signed [SW-1:0] hi);
		if (v > hi) begin
			return hi;
		end else if (v < ~hi) begin
			return ~hi;
		end
		return v;
	endfunction

	assign last = (cnt_q == CW'(NDIG - 1));
	assign stat = '{last: last};

	// The top digit of the operand carries the sign; lower digits are unsigned.
	assign dig  = last ? {r_q[DIGIT_BITS-1], r_q[DIGIT_BITS-1:0]}
		: {1'b0, r_q[DIGIT_BITS-1:0]};
	assign prod = m_q * dig;

	assign mid_v = clamp(acc_q >>> (COEF_FRAC_BITS + 1), LIM_MID);
	assign y_w   = clamp((acc_q + HALF_2) >>> COEF_FRAC_BITS, LIM_Y);
	assign y     = y_w[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				MOP_LOAD, MOP_MID: cnt_q <= '0;
				MOP_STEP:          cnt_q <= cnt_q + CW'(1);
				default:           cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			MOP_LOAD: begin
				acc_q <= cmd.first ? '0 : clamp(acc_q, LIM_64);
				m_q   <= SW'(coef);
				r_q   <= RW'(operand);
			end
			MOP_STEP: begin
				acc_q <= acc_q + signed'(prod[SW-1:0]);
				m_q   <= m_q <<< DIGIT_BITS;
				r_q   <= r_q >>> DIGIT_BITS;
			end
			MOP_RND: begin
				acc_q <= clamp(acc_q + HALF_1, LIM_64);
			end
			MOP_MID: begin
				acc_q <= '0;
				m_q   <= mid_v;
				r_q   <= signed'(RW'(gain));
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule
